// File: hdl/asdg_pkg.sv
// asdg_pkg: shared types, constants and helper functions for the steering delay generator
// used by every module in hdl; depends on nothing else
`timescale 1ns / 1ps

package asdg_pkg;

	// grid limits
	localparam int MAX_SIDE     = 8;
	localparam int MAX_ELEMENTS = 64;
	localparam int SIDE_W       = $clog2(MAX_SIDE);
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = IDX_W + 1;

	// field widths
	localparam int CFG_SIDE_W = 4;
	localparam int CFG_WORD_W = 16;
	localparam int ANGLE_W    = 16;
	localparam int DELAY_W    = 24;
	localparam int RAW_W      = 32;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// cordic
	localparam int CORDIC_STEPS = 15;
	localparam int STEP_W       = 4;
	localparam int CORDIC_W     = 20;
	localparam int ZACC_W       = 18;
	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 20'sd39797;

	// datapath widths
	localparam int HALF_W = 6;
	localparam int T_W    = 27;
	localparam int MUL_W  = T_W + 17;
	localparam int PROD_W = MUL_W + 17;

	// register map, index is paddr[3:2]
	typedef enum logic [1:0] {
		REG_COLUMNS = 2'd0,
		REG_ROWS    = 2'd1,
		REG_SPACING = 2'd2,
		REG_SPM     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_SIDE_W-1:0] grid_columns;
		logic [CFG_SIDE_W-1:0] grid_rows;
		logic [CFG_WORD_W-1:0] element_spacing;
		logic [CFG_WORD_W-1:0] samples_per_metre;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORD_AZ,
		ST_SAVE_AZ,
		ST_CORD_EL,
		ST_SAVE_EL,
		ST_CZ,
		ST_P1_T,
		ST_P1_MUL,
		ST_P1_RAW,
		ST_P1_MIN,
		ST_P2_RD,
		ST_P2_LD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic              cord_step;
		logic [STEP_W-1:0] step;
		logic              save_az;
		logic              save_el;
		logic              calc_cz;
		logic              elem_clr;
		logic              calc_t;
		logic              calc_mul;
		logic              calc_raw;
		logic              upd_min;
		logic              elem_adv;
		logic              mem_rd;
		logic              out_ld;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic elem_last;
		logic out_free;
	} status_t;

	// arctangent of 2^-i in angle codes
	function automatic logic [13:0] arc_code(input logic [STEP_W-1:0] i);
		logic [13:0] r;
		case (i)
			4'd0:    r = 14'd8192;
			4'd1:    r = 14'd4836;
			4'd2:    r = 14'd2555;
			4'd3:    r = 14'd1297;
			4'd4:    r = 14'd651;
			4'd5:    r = 14'd326;
			4'd6:    r = 14'd163;
			4'd7:    r = 14'd81;
			4'd8:    r = 14'd41;
			4'd9:    r = 14'd20;
			4'd10:   r = 14'd10;
			4'd11:   r = 14'd5;
			4'd12:   r = 14'd3;
			4'd13:   r = 14'd1;
			4'd14:   r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

	// side count clamped to 1..MAX_SIDE
	function automatic logic [CFG_SIDE_W-1:0] side_clamp(input logic [CFG_SIDE_W-1:0] v);
		logic [CFG_SIDE_W-1:0] r;
		if (v == '0) begin
			r = CFG_SIDE_W'(1);
		end else if (v > CFG_SIDE_W'(MAX_SIDE)) begin
			r = CFG_SIDE_W'(MAX_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: hdl/asdg_regs.sv
// asdg_regs: configuration registers behind an apb-style port
// depends on asdg_pkg
`timescale 1ns / 1ps

module asdg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [asdg_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [asdg_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [asdg_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output asdg_pkg::cfg_t                   cfg
);
	import asdg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_columns      <= 4'd4;
			cfg_q.grid_rows         <= 4'd4;
			cfg_q.element_spacing   <= 16'd4096;
			cfg_q.samples_per_metre <= 16'd36762;
		end else if (wr_en) begin
			unique case (idx)
				REG_COLUMNS: cfg_q.grid_columns      <= pwdata[CFG_SIDE_W-1:0];
				REG_ROWS:    cfg_q.grid_rows         <= pwdata[CFG_SIDE_W-1:0];
				REG_SPACING: cfg_q.element_spacing   <= pwdata[CFG_WORD_W-1:0];
				REG_SPM:     cfg_q.samples_per_metre <= pwdata[CFG_WORD_W-1:0];
				default:     ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_COLUMNS: prdata = APB_DATA_W'(cfg_q.grid_columns);
			REG_ROWS:    prdata = APB_DATA_W'(cfg_q.grid_rows);
			REG_SPACING: prdata = APB_DATA_W'(cfg_q.element_spacing);
			REG_SPM:     prdata = APB_DATA_W'(cfg_q.samples_per_metre);
			default:     prdata = '0;
		endcase
	end

endmodule

// File: hdl/asdg_ctrl.sv
// asdg_ctrl: sequencing state machine for trig, pass one and pass two
// depends on asdg_pkg
`timescale 1ns / 1ps

module asdg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  asdg_pkg::status_t  status,
	output asdg_pkg::cmd_t     cmd
);
	import asdg_pkg::*;

	state_t            state_q, state_n;
	logic [STEP_W-1:0] step_q;
	logic              step_end;

	assign step_end = (step_q == STEP_W'(CORDIC_STEPS - 1));

	// cordic step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if ((state_q == ST_CORD_AZ) || (state_q == ST_CORD_EL)) begin
			step_q <= step_end ? '0 : step_q + STEP_W'(1);
		end else begin
			step_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_n = ST_CORD_AZ;
			ST_CORD_AZ: if (step_end) state_n = ST_SAVE_AZ;
			ST_SAVE_AZ: state_n = ST_CORD_EL;
			ST_CORD_EL: if (step_end) state_n = ST_SAVE_EL;
			ST_SAVE_EL: state_n = ST_CZ;
			ST_CZ:      state_n = ST_P1_T;
			ST_P1_T:    state_n = ST_P1_MUL;
			ST_P1_MUL:  state_n = ST_P1_RAW;
			ST_P1_RAW:  state_n = ST_P1_MIN;
			ST_P1_MIN:  state_n = status.elem_last ? ST_P2_RD : ST_P1_T;
			ST_P2_RD:   state_n = ST_P2_LD;
			ST_P2_LD: begin
				if (status.out_free) state_n = status.elem_last ? ST_IDLE : ST_P2_RD;
			end
			default:    state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:    cmd.load = in_valid;
			ST_CORD_AZ: cmd.cord_step = 1'b1;
			ST_SAVE_AZ: cmd.save_az = 1'b1;
			ST_CORD_EL: cmd.cord_step = 1'b1;
			ST_SAVE_EL: cmd.save_el = 1'b1;
			ST_CZ: begin
				cmd.calc_cz  = 1'b1;
				cmd.elem_clr = 1'b1;
			end
			ST_P1_T:    cmd.calc_t = 1'b1;
			ST_P1_MUL:  cmd.calc_mul = 1'b1;
			ST_P1_RAW:  cmd.calc_raw = 1'b1;
			ST_P1_MIN: begin
				cmd.upd_min  = 1'b1;
				cmd.elem_clr = status.elem_last;
				cmd.elem_adv = !status.elem_last;
			end
			ST_P2_RD:   cmd.mem_rd = 1'b1;
			ST_P2_LD: begin
				cmd.out_ld   = status.out_free;
				cmd.elem_adv = status.out_free && !status.elem_last;
			end
			default:    ;
		endcase
	end

endmodule

// File: hdl/asdg_dp.sv
// asdg_dp: cordic unit, per-element delay arithmetic, raw delay memory and output register
// depends on asdg_pkg; driven by asdg_ctrl
`timescale 1ns / 1ps

module asdg_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  asdg_pkg::cfg_t                 cfg,
	input  asdg_pkg::cmd_t                 cmd,
	output asdg_pkg::status_t              status,
	input  logic [asdg_pkg::ANGLE_W-1:0]   azimuth,
	input  logic [asdg_pkg::ANGLE_W-1:0]   elevation,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [asdg_pkg::IDX_W-1:0]     element_index,
	output logic [asdg_pkg::DELAY_W-1:0]   delay,
	output logic                           last
);
	import asdg_pkg::*;

	// item registers
	logic [ANGLE_W-1:0]          el_q;
	logic [2*CFG_WORD_W-1:0]     scale_q;

	// cordic registers
	logic signed [CORDIC_W-1:0]  x_q, y_q;
	logic signed [ZACC_W-1:0]    z_q;
	logic                        flip_q;
	logic signed [CORDIC_W-1:0]  ca_q, sa_q, se_q, cz_q;

	// element counters
	logic [SIDE_W-1:0]           col_q, row_q;
	logic [IDX_W-1:0]            k_q;

	// pass one pipeline
	logic signed [T_W-1:0]       t_s1;
	logic signed [MUL_W:0]       p_lo_s2;
	logic signed [MUL_W-1:0]     p_hi_s2;
	logic signed [RAW_W-1:0]     raw_s3;
	logic signed [RAW_W-1:0]     min_q;

	// raw delay memory
	logic [RAW_W-1:0]            mem [MAX_ELEMENTS];
	logic signed [RAW_W-1:0]     rd_q;

	// output register
	logic                        out_valid_q;
	logic [IDX_W-1:0]            idx_q;
	logic [DELAY_W-1:0]          delay_q;
	logic                        last_q;

	logic [CFG_SIDE_W-1:0]       cols, rows;
	logic [CNT_W-1:0]            count;
	logic [2*CFG_SIDE_W-1:0]     prod_cnt;
	logic [ANGLE_W-1:0]          init_code, init_r;
	logic                        init_flip;
	logic signed [CORDIC_W-1:0]  dx, dy;
	logic [13:0]                 arc;
	logic signed [HALF_W-1:0]    u, v;
	logic signed [2*CORDIC_W-1:0] cz_full;
	logic signed [PROD_W-1:0]    sum;
	logic signed [RAW_W:0]       diff;
	logic                        elem_last;

	// effective grid size
	assign cols     = side_clamp(cfg.grid_columns);
	assign rows     = side_clamp(cfg.grid_rows);
	assign prod_cnt = cols * rows;
	assign count    = (prod_cnt > (2*CFG_SIDE_W)'(MAX_ELEMENTS)) ?
		CNT_W'(MAX_ELEMENTS) : prod_cnt[CNT_W-1:0];
	assign elem_last = ((CNT_W'(k_q) + CNT_W'(1)) == count);

	// cordic start: turn codes in the left half plane by half a turn
	assign init_code = cmd.load ? azimuth : el_q;
	assign init_flip = init_code[15] ^ init_code[14];
	assign init_r    = init_flip ? (init_code - 16'h8000) : init_code;

	assign dx  = y_q >>> cmd.step;
	assign dy  = x_q >>> cmd.step;
	assign arc = arc_code(cmd.step);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			el_q    <= elevation;
			scale_q <= cfg.element_spacing * cfg.samples_per_metre;
		end
	end

	// cordic rotation, one step per cycle
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.save_az) begin
			x_q    <= CORDIC_START;
			y_q    <= '0;
			z_q    <= ZACC_W'($signed(init_r));
			flip_q <= init_flip;
		end else if (cmd.cord_step) begin
			if (!z_q[ZACC_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - $signed({4'b0000, arc});
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + $signed({4'b0000, arc});
			end
		end
	end

	// trig results
	assign cz_full = ca_q * se_q;
	always_ff @(posedge clk) begin
		if (cmd.save_az) begin
			ca_q <= flip_q ? -x_q : x_q;
			sa_q <= flip_q ? -y_q : y_q;
		end
		if (cmd.save_el) begin
			se_q <= flip_q ? -y_q : y_q;
		end
		if (cmd.calc_cz) begin
			cz_q <= cz_full[CORDIC_W+15:16];
		end
	end

	// element counters, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			k_q   <= '0;
		end else if (cmd.elem_clr) begin
			col_q <= '0;
			row_q <= '0;
			k_q   <= '0;
		end else if (cmd.elem_adv) begin
			k_q <= k_q + IDX_W'(1);
			if ({1'b0, col_q} == cols - CFG_SIDE_W'(1)) begin
				col_q <= '0;
				row_q <= row_q + SIDE_W'(1);
			end else begin
				col_q <= col_q + SIDE_W'(1);
			end
		end
	end

	// half-pitch offsets from the grid centre
	assign u = $signed({2'b00, col_q, 1'b0}) - $signed({2'b00, cols}) + 6'sd1;
	assign v = $signed({2'b00, row_q, 1'b0}) - $signed({2'b00, rows}) + 6'sd1;

	assign sum = (PROD_W'(p_hi_s2) <<< 16) + PROD_W'(p_lo_s2);

	// pass one: depth, scaling in two partial products, rounding
	always_ff @(posedge clk) begin
		if (cmd.calc_t) begin
			t_s1 <= T_W'(cz_q * v) - T_W'(sa_q * u);
		end
		if (cmd.calc_mul) begin
			p_lo_s2 <= (MUL_W+1)'(t_s1 * $signed({1'b0, scale_q[15:0]})) + 45'sh10000000;
			p_hi_s2 <= t_s1 * $signed({1'b0, scale_q[31:16]});
		end
		if (cmd.calc_raw) begin
			raw_s3 <= sum[RAW_W+28:29];
		end
	end

	// running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
		end else if (cmd.upd_min && ((k_q == '0) || (raw_s3 < min_q))) begin
			min_q <= raw_s3;
		end
	end

	// raw delay memory
	always_ff @(posedge clk) begin
		if (cmd.upd_min) begin
			mem[k_q] <= raw_s3;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[k_q];
		end
	end

	assign diff = {rd_q[RAW_W-1], rd_q} - {min_q[RAW_W-1], min_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			idx_q  <= k_q;
			last_q <= elem_last;
			if (diff[RAW_W]) begin
				delay_q <= '0;
			end else if (diff > (RAW_W+1)'(24'hFFFFFF)) begin
				delay_q <= '1;
			end else begin
				delay_q <= diff[DELAY_W-1:0];
			end
		end
	end

	assign status.elem_last = elem_last;
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign element_index = idx_q;
	assign delay         = delay_q;
	assign last          = last_q;

endmodule

// File: hdl/array_steering_delay_generator_unit.sv
// array_steering_delay_generator_unit: top level of the steering delay generator
// depends on asdg_pkg, asdg_regs, asdg_ctrl and asdg_dp
`timescale 1ns / 1ps

// One request (azimuth, elevation) yields one delay per grid element, row-major, with
// last set on the final element. A request runs 15 cordic steps for each angle; pass
// one then takes each element through depth, two partial products, rounding and a
// memory write with running minimum, and pass two reads each element through the single
// read port of the raw delay memory into the output register, waiting while the output
// stalls. Only one request is in flight; in_stall stays high until the last element
// is in the output register. Configuration must be written while the block is idle.
module array_steering_delay_generator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [asdg_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [asdg_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [asdg_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [asdg_pkg::ANGLE_W-1:0]     azimuth,
	input  logic [asdg_pkg::ANGLE_W-1:0]     elevation,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [asdg_pkg::IDX_W-1:0]       element_index,
	output logic [asdg_pkg::DELAY_W-1:0]     delay,
	output logic                             last
);
	import asdg_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	asdg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	asdg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	asdg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.azimuth       (azimuth),
		.elevation     (elevation),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.element_index (element_index),
		.delay         (delay),
		.last          (last)
	);

endmodule
